// ----- sv/quaternion_to_euler_zyx_defines.svh -----
// Assertion macros shared by the quaternion to Euler angle checker.
`ifndef QUATERNION_TO_EULER_ZYX_DEFINES_SVH
`define QUATERNION_TO_EULER_ZYX_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define QTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/qte_pkg.sv -----
// Package with the fixed-point widths, constants, types and CORDIC helpers.
`timescale 1ns / 1ps

package qte_pkg;

  // Rotation products are Q2.30 regardless of the quaternion width.
  localparam int PROD_W   = 32;
  localparam int RM_W     = 34;
  localparam int SC_W     = 32;
  localparam int SQ_W     = 62;
  localparam int SQ_STEPS = 31;
  localparam int CW       = 37;
  localparam int ZW       = 34;

  localparam logic signed [RM_W-1:0] ONE_Q30    = 34'sd1073741824;
  localparam logic signed [RM_W-1:0] LOCK_LIMIT = 34'sd1073731086;
  localparam logic signed [ZW-1:0]   QUARTER_Z  = 34'sd1073741824;
  localparam logic [SQ_W-1:0]        SQ_ONE     = 62'h1000_0000_0000_0000;

  // Arctangent of 2^-i in units of 2^32 per turn.
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef struct packed {
    logic signed [RM_W-1:0] ry;
    logic signed [RM_W-1:0] rx;
    logic signed [RM_W-1:0] r21;
    logic signed [RM_W-1:0] r22;
    logic signed [SC_W-1:0] sc;
    logic                   lock;
    logic                   sneg;
  } carry_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    lane_t pit;
    lane_t rol;
    lane_t yaw;
    logic  lock;
    logic  sneg;
  } cord_t;

  // Brings a vector into the right half plane and notes the zero vector.
  function automatic lane_t cordic_pre(input logic signed [CW-1:0] y,
                                       input logic signed [CW-1:0] x);
    lane_t o;
    o.x    = x;
    o.y    = y;
    o.z    = '0;
    o.zero = (x == '0) && (y == '0);
    if (x[CW-1]) begin
      if (!y[CW-1]) begin
        o.x = y;
        o.y = -x;
        o.z = QUARTER_Z;
      end else begin
        o.x = -y;
        o.y = x;
        o.z = -QUARTER_Z;
      end
    end
    return o;
  endfunction

  // One vectoring micro-rotation by atan(2^-sh).
  function automatic lane_t cordic_step(input lane_t l, input int unsigned sh,
                                        input logic [31:0] ang);
    lane_t o;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = l.x >>> sh;
    dy = l.y >>> sh;
    o  = l;
    if (!l.y[CW-1]) begin
      o.x = l.x + dy;
      o.y = l.y - dx;
      o.z = l.z + ZW'(ang);
    end else begin
      o.x = l.x - dy;
      o.y = l.y + dx;
      o.z = l.z - ZW'(ang);
    end
    return o;
  endfunction

endpackage

// ----- sv/qte_if.sv -----
// Request channel interfaces for the quaternion input and the Euler angle result.
`timescale 1ns / 1ps

interface qte_in_if #(
  parameter int QUAT_BITS = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [QUAT_BITS-1:0] quat_w;
  logic signed [QUAT_BITS-1:0] quat_x;
  logic signed [QUAT_BITS-1:0] quat_y;
  logic signed [QUAT_BITS-1:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y,
                input quat_z, output ready);
endinterface

interface qte_out_if #(
  parameter int ANGLE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] pitch_angle;
  logic signed [ANGLE_BITS-1:0] roll_angle;
  logic signed [ANGLE_BITS-1:0] yaw_angle;
  logic                         gimbal_lock;

  modport source (output valid, output pitch_angle, output roll_angle,
                  output yaw_angle, output gimbal_lock, input ready);
  modport sink (input valid, input pitch_angle, input roll_angle,
                input yaw_angle, input gimbal_lock, output ready);
endinterface

// ----- sv/quaternion_to_euler_zyx.sv -----
// Pipelined quaternion to ZYX Euler angle converter, top level.
// Data flows through the product, matrix, sqrt, CORDIC and output registers.
// Throughput: one quaternion per cycle; the whole pipeline advances while the skid is empty.
// Depth is set by the 31-stage square-root pipeline and one stage per CORDIC iteration.
// Reset clears the stage valid bits and the output/skid flags; data registers are not reset.
`timescale 1ns / 1ps

module quaternion_to_euler_zyx #(
  parameter int QUAT_BITS    = 16,
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input logic       clk,
  input logic       rst_n,
  qte_in_if.sink    in_chan,
  qte_out_if.source out_chan
);

  localparam int PW    = 2 * QUAT_BITS;
  localparam int FRAC  = 2 * QUAT_BITS - 2;
  localparam int SH    = 32 - ANGLE_BITS;
  localparam int NST   = 4 + qte_pkg::SQ_STEPS + CORDIC_STEPS;
  localparam int RM_W  = qte_pkg::RM_W;
  localparam int ZW    = qte_pkg::ZW;
  localparam int CW    = qte_pkg::CW;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] pitch;
    logic [ANGLE_BITS-1:0] roll;
    logic [ANGLE_BITS-1:0] yaw;
    logic                  lock;
  } res_t;

  logic [NST-1:0] v_r;
  logic           en;
  logic           incoming;
  logic           ov_r;
  logic           sv_r;

  // The pipeline only halts when the skid register is occupied.
  assign en            = !sv_r;
  assign in_chan.ready = en;
  assign incoming      = en && v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_chan.valid};
    end
  end

  // Stage 0: the nine quaternion products, rescaled to Q2.30.
  logic signed [QUAT_BITS-1:0]      opa [9];
  logic signed [QUAT_BITS-1:0]      opb [9];
  logic signed [qte_pkg::PROD_W-1:0] q30 [9];
  logic signed [qte_pkg::PROD_W-1:0] p_r [9];

  always_comb begin
    opa[0] = in_chan.quat_x; opb[0] = in_chan.quat_x;
    opa[1] = in_chan.quat_y; opb[1] = in_chan.quat_y;
    opa[2] = in_chan.quat_z; opb[2] = in_chan.quat_z;
    opa[3] = in_chan.quat_x; opb[3] = in_chan.quat_y;
    opa[4] = in_chan.quat_x; opb[4] = in_chan.quat_z;
    opa[5] = in_chan.quat_y; opb[5] = in_chan.quat_z;
    opa[6] = in_chan.quat_w; opb[6] = in_chan.quat_x;
    opa[7] = in_chan.quat_w; opb[7] = in_chan.quat_y;
    opa[8] = in_chan.quat_w; opb[8] = in_chan.quat_z;
  end

  for (genvar k = 0; k < 9; k++) begin : g_mul
    logic signed [PW-1:0] prod;
    assign prod = opa[k] * opb[k];
    if (FRAC >= 30) begin : g_dn
      logic signed [PW-1:0] shr;
      assign shr    = prod >>> (FRAC - 30);
      assign q30[k] = shr[qte_pkg::PROD_W-1:0];
    end else begin : g_up
      logic signed [qte_pkg::PROD_W-1:0] ext;
      assign ext    = qte_pkg::PROD_W'(prod);
      assign q30[k] = ext <<< (30 - FRAC);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        p_r[k] <= q30[k];
      end
    end
  end

  // Stage 1: rotation matrix entries, sine of pitch and the lock decision.
  logic signed [RM_W-1:0] e [9];
  logic signed [RM_W-1:0] r00, r01, r10, r11, r20, r21, r22;
  logic signed [RM_W-1:0] s_val, mag, scl;
  logic                   lock_c;
  qte_pkg::carry_t        c1_nxt;
  qte_pkg::carry_t        c1_r;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e[k] = RM_W'(p_r[k]);
    end
    r00    = qte_pkg::ONE_Q30 - ((e[1] + e[2]) <<< 1);
    r01    = (e[3] - e[8]) <<< 1;
    r10    = (e[3] + e[8]) <<< 1;
    r11    = qte_pkg::ONE_Q30 - ((e[0] + e[2]) <<< 1);
    r20    = (e[4] - e[7]) <<< 1;
    r21    = (e[5] + e[6]) <<< 1;
    r22    = qte_pkg::ONE_Q30 - ((e[0] + e[1]) <<< 1);
    s_val  = -r20;
    mag    = s_val[RM_W-1] ? -s_val : s_val;
    lock_c = mag > qte_pkg::LOCK_LIMIT;
    if (s_val > qte_pkg::ONE_Q30) begin
      scl = qte_pkg::ONE_Q30;
    end else if (s_val < -qte_pkg::ONE_Q30) begin
      scl = -qte_pkg::ONE_Q30;
    end else begin
      scl = s_val;
    end
    // In gimbal lock the yaw comes from R01 and R11 instead of R10 and R00.
    c1_nxt.ry   = lock_c ? r01 : r10;
    c1_nxt.rx   = lock_c ? r11 : r00;
    c1_nxt.r21  = r21;
    c1_nxt.r22  = r22;
    c1_nxt.sc   = scl[qte_pkg::SC_W-1:0];
    c1_nxt.lock = lock_c;
    c1_nxt.sneg = s_val[RM_W-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= c1_nxt;
    end
  end

  // Stage 2: cosine squared of pitch, 1 - s*s in Q2.60.
  logic signed [63:0] scsq;
  qte_pkg::sqrt_t     s2_nxt;
  qte_pkg::sqrt_t     s2_r;
  qte_pkg::carry_t    s2c_r;

  assign scsq       = c1_r.sc * c1_r.sc;
  assign s2_nxt.rem = qte_pkg::SQ_ONE - scsq[qte_pkg::SQ_W-1:0];
  assign s2_nxt.res = '0;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r  <= s2_nxt;
      s2c_r <= c1_r;
    end
  end

  // Square-root pipeline: one result bit per stage.
  qte_pkg::sqrt_t  sq_r  [qte_pkg::SQ_STEPS];
  qte_pkg::carry_t sqc_r [qte_pkg::SQ_STEPS];

  for (genvar j = 0; j < qte_pkg::SQ_STEPS; j++) begin : g_sqrt
    localparam logic [qte_pkg::SQ_W-1:0] BIT = qte_pkg::SQ_W'(1) << (60 - 2 * j);
    qte_pkg::sqrt_t              src;
    qte_pkg::sqrt_t              nxt;
    qte_pkg::carry_t             csrc;
    logic [qte_pkg::SQ_W-1:0]    trial;
    if (j == 0) begin : g_first
      assign src  = s2_r;
      assign csrc = s2c_r;
    end else begin : g_next
      assign src  = sq_r[j-1];
      assign csrc = sqc_r[j-1];
    end
    always_comb begin
      trial = src.res + BIT;
      if (src.rem >= trial) begin
        nxt.rem = src.rem - trial;
        nxt.res = (src.res >> 1) + BIT;
      end else begin
        nxt.rem = src.rem;
        nxt.res = src.res >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[j]  <= nxt;
        sqc_r[j] <= csrc;
      end
    end
  end

  // CORDIC entry: three vectors, each rotated into the right half plane.
  qte_pkg::sqrt_t  sq_last;
  qte_pkg::carry_t cq_last;
  qte_pkg::cord_t  cp_nxt;
  qte_pkg::cord_t  cp_r;

  assign sq_last = sq_r[qte_pkg::SQ_STEPS-1];
  assign cq_last = sqc_r[qte_pkg::SQ_STEPS-1];

  always_comb begin
    cp_nxt.pit  = qte_pkg::cordic_pre(CW'(cq_last.sc), CW'(sq_last.res[30:0]));
    cp_nxt.rol  = qte_pkg::cordic_pre(CW'(cq_last.r21), CW'(cq_last.r22));
    cp_nxt.yaw  = qte_pkg::cordic_pre(CW'(cq_last.ry), CW'(cq_last.rx));
    cp_nxt.lock = cq_last.lock;
    cp_nxt.sneg = cq_last.sneg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_r <= cp_nxt;
    end
  end

  // CORDIC pipeline: one micro-rotation per stage on all three lanes.
  qte_pkg::cord_t cd_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    qte_pkg::cord_t src;
    qte_pkg::cord_t nxt;
    if (i == 0) begin : g_first
      assign src = cp_r;
    end else begin : g_next
      assign src = cd_r[i-1];
    end
    always_comb begin
      nxt      = src;
      nxt.pit  = qte_pkg::cordic_step(src.pit, i, qte_pkg::ATAN_TAB[i]);
      nxt.rol  = qte_pkg::cordic_step(src.rol, i, qte_pkg::ATAN_TAB[i]);
      nxt.yaw  = qte_pkg::cordic_step(src.yaw, i, qte_pkg::ATAN_TAB[i]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cd_r[i] <= nxt;
      end
    end
  end

  // Final angle selection and rounding to the output angle width.
  qte_pkg::cord_t         last;
  logic signed [ZW-1:0]   zsel [3];
  logic signed [ZW-1:0]   yaw_raw;
  logic [ANGLE_BITS-1:0]  ang  [3];
  res_t                   res_nxt;
  res_t                   res_r;
  res_t                   skid_r;

  assign last = cd_r[CORDIC_STEPS-1];

  always_comb begin
    if (last.lock) begin
      zsel[0] = last.sneg ? -qte_pkg::QUARTER_Z : qte_pkg::QUARTER_Z;
    end else begin
      zsel[0] = last.pit.zero ? '0 : last.pit.z;
    end
    zsel[1] = (last.lock || last.rol.zero) ? '0 : last.rol.z;
    yaw_raw = last.yaw.zero ? '0 : last.yaw.z;
    zsel[2] = (last.lock && last.sneg) ? -yaw_raw : yaw_raw;
  end

  for (genvar a = 0; a < 3; a++) begin : g_round
    if (SH > 0) begin : g_rnd
      localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (SH - 1);
      logic signed [ZW-1:0] zr;
      assign zr     = (zsel[a] + HALF) >>> SH;
      assign ang[a] = zr[ANGLE_BITS-1:0];
    end else begin : g_full
      assign ang[a] = zsel[a][ANGLE_BITS-1:0];
    end
  end

  assign res_nxt.pitch = ang[0];
  assign res_nxt.roll  = ang[1];
  assign res_nxt.yaw   = ang[2];
  assign res_nxt.lock  = last.lock;

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (incoming) begin
      if (!ov_r || out_chan.ready) begin
        ov_r <= 1'b1;
      end else begin
        sv_r <= 1'b1;
      end
    end else if (ov_r && out_chan.ready) begin
      if (sv_r) begin
        sv_r <= 1'b0;
      end else begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (incoming) begin
      if (!ov_r || out_chan.ready) begin
        res_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end else if (ov_r && out_chan.ready && sv_r) begin
      res_r <= skid_r;
    end
  end

  assign out_chan.valid       = ov_r;
  assign out_chan.pitch_angle = res_r.pitch;
  assign out_chan.roll_angle  = res_r.roll;
  assign out_chan.yaw_angle   = res_r.yaw;
  assign out_chan.gimbal_lock = res_r.lock;

endmodule

// ----- sv/qte_checker.sv -----
// Port-level assertion checker for the Euler angle converter and its bind.
`timescale 1ns / 1ps
`include "quaternion_to_euler_zyx_defines.svh"

module qte_assertions #(
  parameter int ANGLE_BITS = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [ANGLE_BITS-1:0] pitch_angle,
  input logic signed [ANGLE_BITS-1:0] roll_angle,
  input logic                         gimbal_lock
);

  localparam logic signed [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic lock_pitch_ok;

  assign lock_pitch_ok = (pitch_angle == QTR) || (pitch_angle == -QTR);

  // A pending result may not be withdrawn.
  `QTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Input backpressure only happens when a result is waiting in the output register.
  `QTE_ASSERT_NOW(a_stall_has_result, !in_ready, out_valid, "input stalled without a result")

  // In gimbal lock roll is forced to zero.
  `QTE_ASSERT_NOW(a_lock_roll, out_valid && gimbal_lock, roll_angle == '0, "roll not zero in lock")

  // In gimbal lock pitch is exactly a quarter turn up or down.
  `QTE_ASSERT_NOW(a_lock_pitch, out_valid && gimbal_lock, lock_pitch_ok, "lock pitch not a quarter")

endmodule

bind quaternion_to_euler_zyx qte_assertions #(
  .ANGLE_BITS (ANGLE_BITS)
) u_qte_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .pitch_angle (out_chan.pitch_angle),
  .roll_angle  (out_chan.roll_angle),
  .gimbal_lock (out_chan.gimbal_lock)
);
